@@ design/scs_pkg.sv @@
`timescale 1ns / 1ps

package scs_pkg;

	// Defaults for the top-level parameters.
	localparam int RAMP_SHIFT_DEF      = 10;
	localparam int PAN_TABLE_DEPTH_DEF = 256;

	// Fixed-point constants.
	localparam logic [15:0] UNITY_Q15   = 16'd32768;
	localparam longint      HALF_PI_Q30 = 64'sd1686629713;
	localparam longint      ONE_Q30     = 64'sd1073741824;

	// Denominators (2n-1)*(2n) of the cosine series terms.
	localparam longint TAYLOR_DIV [10] = '{
		64'sd2, 64'sd12, 64'sd30, 64'sd56, 64'sd90,
		64'sd132, 64'sd182, 64'sd240, 64'sd306, 64'sd380
	};

	// Serial multiplier widths: signed multiplicand, unsigned multiplier,
	// raw result holds the high accumulator and the shifted-out low bits.
	localparam int MUL_MC_W  = 24;
	localparam int MUL_MP_W  = 32;
	localparam int MUL_RAW_W = MUL_MC_W + 3 + MUL_MP_W;

	// Configuration register indexes.
	typedef logic [2:0] cfg_index_t;
	localparam cfg_index_t CFG_VOLUME_TARGET = 3'd0;
	localparam cfg_index_t CFG_PAN_TARGET    = 3'd1;
	localparam cfg_index_t CFG_MUTE_ENABLE   = 3'd2;
	localparam cfg_index_t CFG_DELAY_SEND    = 3'd3;
	localparam cfg_index_t CFG_GRAIN_SEND    = 3'd4;
	localparam cfg_index_t CFG_REVERB_SEND   = 3'd5;

	typedef struct packed {
		logic       we;
		cfg_index_t index;
		logic [15:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic       start;
		logic [3:0] last_step;
	} mul_cmd_t;

	typedef struct packed {
		logic signed [23:0] in_left;
		logic signed [23:0] in_right;
		logic               block_end;
	} sample_t;

	typedef struct packed {
		logic signed [23:0] out_left;
		logic signed [23:0] out_right;
		logic signed [23:0] delay_left;
		logic signed [23:0] delay_right;
		logic signed [23:0] grain_left;
		logic signed [23:0] grain_right;
		logic signed [23:0] reverb_left;
		logic signed [23:0] reverb_right;
		logic [23:0]        input_peak;
		logic [23:0]        output_peak;
		logic               block_done;
	} result_t;

	// Gains above unity are held at unity.
	function automatic logic [15:0] clamp_gain(input logic [15:0] g);
		return (g > UNITY_Q15) ? UNITY_Q15 : g;
	endfunction

	// Magnitude of a 24-bit sample; the most negative value maps to 2^23.
	function automatic logic [23:0] abs24(input logic signed [23:0] x);
		return x[23] ? 24'(-x) : 24'(x);
	endfunction

	// Saturate a wider signed value to 24 bits.
	function automatic logic signed [23:0] sat24(input logic signed [28:0] x);
		logic signed [23:0] r;
		if (x > 29'sd8388607) begin
			r = 24'sh7FFFFF;
		end else if (x < -29'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = x[23:0];
		end
		return r;
	endfunction

	// One cosine table entry in Q1.15 from an angle in Q2.30, by the constant term and ten further terms of the series.
	function automatic logic [15:0] cos_q15(input longint x);
		longint x2;
		longint term;
		longint sum;
		x2 = (x * x) >>> 30;
		term = ONE_Q30;
		sum = ONE_Q30;
		for (int n = 1; n <= 10; n++) begin
			term = ((term * x2) >>> 30) / TAYLOR_DIV[n - 1];
			if (n[0]) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		sum = (sum + 64'sd16384) >>> 15;
		if (sum > 64'sd32768) begin
			sum = 64'sd32768;
		end
		return 16'(sum);
	endfunction

endpackage

@@ design/scs_stream_if.sv @@
`timescale 1ns / 1ps

// Input channel: one stereo sample pair per item.
interface scs_sample_if import scs_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// Output channel: direct pair, sends and meters per item.
interface scs_result_if import scs_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/scs_pan_rom.sv @@
`timescale 1ns / 1ps

module scs_pan_rom import scs_pkg::*; #(
	parameter int DEPTH = PAN_TABLE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic [$clog2(DEPTH + 1) - 1:0] idx_l,
	input  logic [$clog2(DEPTH + 1) - 1:0] idx_r,
	output logic [15:0]                    data_l,
	output logic [15:0]                    data_r
);

	logic [15:0] tab [DEPTH + 1];

	// Quarter-wave cosine table, built at elaboration.
	for (genvar k = 0; k <= DEPTH; k++) begin : g_tab
		localparam longint XK = (longint'(k) * HALF_PI_Q30) / DEPTH;
		assign tab[k] = cos_q15(XK);
	end

	// One registered read port per lane.
	always_ff @(posedge clk) begin
		data_l <= tab[idx_l];
		data_r <= tab[idx_r];
	end

endmodule

@@ design/scs_smul.sv @@
`timescale 1ns / 1ps

module scs_smul import scs_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mul_cmd_t                    cmd,
	input  logic signed [MUL_MC_W-1:0]  mcand,
	input  logic [MUL_MP_W-1:0]         mplier,
	output logic                        done,
	output logic signed [MUL_RAW_W-1:0] raw
);

	localparam int HW = MUL_MC_W + 3;

	logic signed [HW-1:0] mc_ext;
	logic signed [HW-1:0] mc1_q;
	logic signed [HW-1:0] mc3_q;
	logic signed [HW-1:0] hi_q;
	logic signed [HW-1:0] partial;
	logic signed [HW-1:0] sum;
	logic [MUL_MP_W-1:0]  mp_q;
	logic [MUL_MP_W-1:0]  lo_q;
	logic [3:0]           cnt_q;
	logic                 busy_q;
	logic                 done_q;

	assign mc_ext = {{3{mcand[MUL_MC_W-1]}}, mcand};

	// Pick the multiple for the current two-bit digit.
	always_comb begin
		unique case (mp_q[1:0])
			2'd0: partial = '0;
			2'd1: partial = mc1_q;
			2'd2: partial = mc1_q <<< 1;
			2'd3: partial = mc3_q;
			default: partial = '0;
		endcase
	end

	assign sum = hi_q + partial;

	// Control: run last_step + 1 digit steps, then flag done for one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Datapath: add the digit multiple, then shift the pair right by one digit.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mc1_q <= mc_ext;
			mc3_q <= mc_ext + (mc_ext <<< 1);
			mp_q  <= mplier;
			cnt_q <= cmd.last_step;
			hi_q  <= '0;
			lo_q  <= '0;
		end else if (busy_q) begin
			hi_q  <= sum >>> 2;
			lo_q  <= {sum[1:0], lo_q[MUL_MP_W-1:2]};
			mp_q  <= {2'b00, mp_q[MUL_MP_W-1:2]};
			cnt_q <= cnt_q - 4'd1;
		end
	end

	assign done = done_q;
	assign raw  = {hi_q, lo_q};

endmodule

@@ design/scs_ramp.sv @@
`timescale 1ns / 1ps

module scs_ramp import scs_pkg::*; #(
	parameter int RAMP_SHIFT = RAMP_SHIFT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_wr_t            cfg,
	input  logic               advance,
	output logic [15:0]        vol,
	output logic signed [15:0] pan
);

	localparam logic [RAMP_SHIFT:0] RAMP_LEN = (RAMP_SHIFT + 1)'(1 << RAMP_SHIFT);
	localparam logic signed [33:0] RAMP_BIAS = 34'((64'sd1 <<< RAMP_SHIFT) - 64'sd1);

	logic [15:0]        vol_tgt_q;
	logic signed [15:0] pan_tgt_q;
	logic [31:0]        vol_now_q;
	logic [31:0]        pan_now_q;
	logic [31:0]        vol_step_q;
	logic [31:0]        pan_step_q;
	logic [RAMP_SHIFT:0] ramp_q;

	logic               wr_vol;
	logic               wr_pan;
	logic [15:0]        vol_tgt_new;
	logic signed [15:0] pan_tgt_new;
	logic signed [33:0] dv;
	logic signed [33:0] dp;
	logic signed [33:0] dv_b;
	logic signed [33:0] dp_b;

	assign wr_vol = cfg.we && (cfg.index == CFG_VOLUME_TARGET);
	assign wr_pan = cfg.we && (cfg.index == CFG_PAN_TARGET);
	assign vol_tgt_new = wr_vol ? clamp_gain(cfg.data) : vol_tgt_q;
	assign pan_tgt_new = wr_pan ? $signed(cfg.data) : pan_tgt_q;

	// Distance to target, divided by the ramp length with truncation toward zero.
	assign dv = $signed({2'b00, vol_tgt_new, 16'h0000}) - $signed({2'b00, vol_now_q});
	assign dp = $signed({{2{pan_tgt_new[15]}}, pan_tgt_new, 16'h0000})
		- $signed({{2{pan_now_q[31]}}, pan_now_q});
	assign dv_b = dv + (dv[33] ? RAMP_BIAS : 34'sd0);
	assign dp_b = dp + (dp[33] ? RAMP_BIAS : 34'sd0);

	// Targets, ramp restart on a target write, one ramp step per advancing item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_tgt_q  <= UNITY_Q15;
			pan_tgt_q  <= '0;
			vol_now_q  <= {UNITY_Q15, 16'h0000};
			pan_now_q  <= '0;
			vol_step_q <= '0;
			pan_step_q <= '0;
			ramp_q     <= '0;
		end else if (wr_vol || wr_pan) begin
			vol_tgt_q  <= vol_tgt_new;
			pan_tgt_q  <= pan_tgt_new;
			vol_step_q <= 32'(dv_b >>> RAMP_SHIFT);
			pan_step_q <= 32'(dp_b >>> RAMP_SHIFT);
			ramp_q     <= RAMP_LEN;
		end else if (advance && ramp_q != '0) begin
			ramp_q <= ramp_q - (RAMP_SHIFT + 1)'(1);
			if (ramp_q == (RAMP_SHIFT + 1)'(1)) begin
				vol_now_q <= {vol_tgt_q, 16'h0000};
				pan_now_q <= {pan_tgt_q, 16'h0000};
			end else begin
				vol_now_q <= vol_now_q + vol_step_q;
				pan_now_q <= pan_now_q + pan_step_q;
			end
		end
	end

	assign vol = (vol_now_q[31:16] > UNITY_Q15) ? UNITY_Q15 : vol_now_q[31:16];
	assign pan = $signed(pan_now_q[31:16]);

endmodule

@@ design/stereo_channel_strip_unit.sv @@
`timescale 1ns / 1ps
// An unmuted item passes through the table reads and the two-bit-per-cycle serial
// multipliers (one per lane), which run six multiplications in sequence; a muted
// item goes from S_IDLE straight to S_FINISH. From S_FINISH an item reaches the
// output register when it is free; a new item is accepted only in S_IDLE. Reset
// (arst_n low) restores unity volume, centre pan, no ramp, zero sends, unmuted
// and cleared peak meters.
module stereo_channel_strip_unit import scs_pkg::*; #(
	parameter int RAMP_SHIFT      = RAMP_SHIFT_DEF,
	parameter int PAN_TABLE_DEPTH = PAN_TABLE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	scs_sample_if.sink        sample,
	scs_result_if.source      result,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_wdata
);

	localparam int IW = $clog2(PAN_TABLE_DEPTH + 1);
	localparam int PW = IW + 16;
	localparam logic [IW-1:0] DEPTH_I = IW'(PAN_TABLE_DEPTH);

	typedef enum logic [9:0] {
		S_IDLE     = 10'b0000000001,
		S_TAB_A    = 10'b0000000010,
		S_TAB_B    = 10'b0000000100,
		S_GO_G     = 10'b0000001000,
		S_MUL_G    = 10'b0000010000,
		S_MUL_VG   = 10'b0000100000,
		S_MUL_IN   = 10'b0001000000,
		S_GO_SEND  = 10'b0010000000,
		S_MUL_SEND = 10'b0100000000,
		S_FINISH   = 10'b1000000000
	} state_t;

	state_t state_q;
	state_t state_d;

	cfg_wr_t cfg_w;
	logic        mute_q;
	logic [15:0] send_gain_q [3];

	logic               accept;
	logic               advance;
	logic               load_out;
	logic signed [23:0] il_q;
	logic signed [23:0] ir_q;
	logic               blk_q;
	logic [23:0]        in_peak_q;
	logic [23:0]        out_peak_q;
	logic [23:0]        in_peak_new;
	logic [23:0]        out_peak_new;

	logic [15:0]        vol_cur;
	logic signed [15:0] pan_cur;
	logic [15:0]        pan_u;
	logic [PW-1:0]      pos;
	logic [IW-1:0]      idx;
	logic [15:0]        frac;
	logic [IW-1:0]      idx_a [2];
	logic [IW-1:0]      idx_b [2];
	logic [IW-1:0]      rom_idx [2];
	logic [15:0]        rom_data [2];
	logic [15:0]        a_q [2];

	mul_cmd_t                   mul_cmd;
	logic signed [MUL_MC_W-1:0] mul_mc [2];
	logic [MUL_MP_W-1:0]        mul_mp [2];
	logic                       mul_done [2];
	logic signed [MUL_RAW_W-1:0] mul_raw [2];

	logic signed [16:0]          diff [2];
	logic [16:0]                 g_sum [2];
	logic [30:0]                 vg_new [2];
	logic signed [MUL_RAW_W-1:0] o_rnd [2];
	logic signed [23:0]          o_new [2];
	logic signed [42:0]          s_rnd [2];
	logic signed [23:0]          snd_new [2];
	logic signed [23:0]          o_q [2];
	logic signed [23:0]          snd_q [2][3];
	logic [1:0]                  send_k_q;
	logic [15:0]                 next_gain;

	logic    out_valid_q;
	result_t out_q;

	assign cfg_w = '{we: cfg_we, index: cfg_index, data: cfg_wdata};

	// Mute and send levels; the ramp unit keeps the volume and pan targets.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mute_q         <= 1'b0;
			send_gain_q[0] <= '0;
			send_gain_q[1] <= '0;
			send_gain_q[2] <= '0;
		end else if (cfg_w.we) begin
			if (cfg_w.index == CFG_MUTE_ENABLE) begin
				mute_q <= cfg_w.data[0];
			end
			if (cfg_w.index == CFG_DELAY_SEND) begin
				send_gain_q[0] <= clamp_gain(cfg_w.data);
			end
			if (cfg_w.index == CFG_GRAIN_SEND) begin
				send_gain_q[1] <= clamp_gain(cfg_w.data);
			end
			if (cfg_w.index == CFG_REVERB_SEND) begin
				send_gain_q[2] <= clamp_gain(cfg_w.data);
			end
		end
	end

	assign sample.ready = (state_q == S_IDLE);
	assign accept       = sample.valid && sample.ready;
	assign advance      = accept && !mute_q;

	scs_ramp #(
		.RAMP_SHIFT (RAMP_SHIFT)
	) u_ramp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_w),
		.advance (advance),
		.vol     (vol_cur),
		.pan     (pan_cur)
	);

	// Pan position to table index and interpolation fraction.
	assign pan_u = {~pan_cur[15], pan_cur[14:0]};
	assign pos   = PW'(pan_u) * PW'(PAN_TABLE_DEPTH);
	assign idx   = pos[PW-1:16];
	assign frac  = pos[15:0];

	assign idx_a[0] = idx;
	assign idx_b[0] = idx + IW'(1);
	assign idx_a[1] = DEPTH_I - idx;
	assign idx_b[1] = DEPTH_I - idx - IW'(1);

	assign rom_idx[0] = (state_q == S_TAB_A) ? idx_a[0] : idx_b[0];
	assign rom_idx[1] = (state_q == S_TAB_A) ? idx_a[1] : idx_b[1];

	scs_pan_rom #(
		.DEPTH (PAN_TABLE_DEPTH)
	) u_rom (
		.clk    (clk),
		.idx_l  (rom_idx[0]),
		.idx_r  (rom_idx[1]),
		.data_l (rom_data[0]),
		.data_r (rom_data[1])
	);

	// Per-lane result extraction from the raw multiplier output.
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			diff[l]    = $signed({1'b0, rom_data[l]}) - $signed({1'b0, a_q[l]});
			g_sum[l]   = {1'b0, a_q[l]} + mul_raw[l][48:32];
			vg_new[l]  = mul_raw[l][46:16];
			o_rnd[l]   = mul_raw[l] + MUL_RAW_W'(64'sd536870912);
			o_new[l]   = sat24(o_rnd[l][58:30]);
			s_rnd[l]   = mul_raw[l][58:16] + 43'sd16384;
			snd_new[l] = sat24({s_rnd[l][42], s_rnd[l][42:15]});
		end
	end

	// Send level for the send after the current one.
	always_comb begin
		unique case (send_k_q)
			2'd0: next_gain = send_gain_q[1];
			2'd1: next_gain = send_gain_q[2];
			default: next_gain = send_gain_q[0];
		endcase
	end

	// Multiplier command and operands: gain interpolation, volume times gain,
	// sample times combined gain, then the three sends.
	always_comb begin
		mul_cmd.start     = 1'b0;
		mul_cmd.last_step = 4'd7;
		for (int l = 0; l < 2; l++) begin
			mul_mc[l] = '0;
			mul_mp[l] = '0;
		end
		unique case (state_q)
			S_GO_G: begin
				mul_cmd.start = 1'b1;
				for (int l = 0; l < 2; l++) begin
					mul_mc[l] = {{7{diff[l][16]}}, diff[l]};
					mul_mp[l] = {16'h0000, frac};
				end
			end
			S_MUL_G: begin
				mul_cmd.start = mul_done[0];
				for (int l = 0; l < 2; l++) begin
					mul_mc[l] = {8'h00, g_sum[l][15:0]};
					mul_mp[l] = {16'h0000, vol_cur};
				end
			end
			S_MUL_VG: begin
				mul_cmd.start     = mul_done[0];
				mul_cmd.last_step = 4'd15;
				mul_mc[0] = il_q;
				mul_mc[1] = ir_q;
				for (int l = 0; l < 2; l++) begin
					mul_mp[l] = {1'b0, vg_new[l]};
				end
			end
			S_GO_SEND: begin
				mul_cmd.start = 1'b1;
				for (int l = 0; l < 2; l++) begin
					mul_mc[l] = o_q[l];
					mul_mp[l] = {16'h0000, send_gain_q[0]};
				end
			end
			S_MUL_SEND: begin
				mul_cmd.start = mul_done[0] && (send_k_q != 2'd2);
				for (int l = 0; l < 2; l++) begin
					mul_mc[l] = o_q[l];
					mul_mp[l] = {16'h0000, next_gain};
				end
			end
			default: begin
				mul_cmd.start = 1'b0;
			end
		endcase
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		scs_smul u_mul (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (mul_cmd),
			.mcand  (mul_mc[l]),
			.mplier (mul_mp[l]),
			.done   (mul_done[l]),
			.raw    (mul_raw[l])
		);
	end

	// Sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = mute_q ? S_FINISH : S_TAB_A;
				end
			end
			S_TAB_A:    state_d = S_TAB_B;
			S_TAB_B:    state_d = S_GO_G;
			S_GO_G:     state_d = S_MUL_G;
			S_MUL_G:    if (mul_done[0]) state_d = S_MUL_VG;
			S_MUL_VG:   if (mul_done[0]) state_d = S_MUL_IN;
			S_MUL_IN:   if (mul_done[0]) state_d = S_GO_SEND;
			S_GO_SEND:  state_d = S_MUL_SEND;
			S_MUL_SEND: if (mul_done[0] && send_k_q == 2'd2) state_d = S_FINISH;
			S_FINISH:   if (load_out) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Item capture and intermediate results.
	always_ff @(posedge clk) begin
		if (accept) begin
			il_q  <= sample.data.in_left;
			ir_q  <= sample.data.in_right;
			blk_q <= sample.data.block_end;
		end
		if (state_q == S_TAB_B) begin
			a_q[0] <= rom_data[0];
			a_q[1] <= rom_data[1];
		end
		if (state_q == S_MUL_IN && mul_done[0]) begin
			o_q[0] <= o_new[0];
			o_q[1] <= o_new[1];
		end
		if (state_q == S_GO_SEND) begin
			send_k_q <= 2'd0;
		end else if (state_q == S_MUL_SEND && mul_done[0]) begin
			snd_q[0][send_k_q] <= snd_new[0];
			snd_q[1][send_k_q] <= snd_new[1];
			send_k_q <= send_k_q + 2'd1;
		end
	end

	// Peak meters.
	always_comb begin
		in_peak_new = in_peak_q;
		if (abs24(sample.data.in_left) > in_peak_new) begin
			in_peak_new = abs24(sample.data.in_left);
		end
		if (abs24(sample.data.in_right) > in_peak_new) begin
			in_peak_new = abs24(sample.data.in_right);
		end
		out_peak_new = out_peak_q;
		if (abs24(o_q[0]) > out_peak_new) begin
			out_peak_new = abs24(o_q[0]);
		end
		if (abs24(o_q[1]) > out_peak_new) begin
			out_peak_new = abs24(o_q[1]);
		end
		if (mute_q) begin
			out_peak_new = '0;
		end
	end

	assign load_out = (state_q == S_FINISH) && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_peak_q  <= '0;
			out_peak_q <= '0;
		end else if (accept) begin
			in_peak_q <= in_peak_new;
		end else if (load_out) begin
			in_peak_q  <= blk_q ? '0 : in_peak_q;
			out_peak_q <= blk_q ? '0 : out_peak_new;
		end
	end

	// Output register; the next item may be accepted while this one waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.out_left     <= mute_q ? '0 : o_q[0];
			out_q.out_right    <= mute_q ? '0 : o_q[1];
			out_q.delay_left   <= mute_q ? '0 : snd_q[0][0];
			out_q.delay_right  <= mute_q ? '0 : snd_q[1][0];
			out_q.grain_left   <= mute_q ? '0 : snd_q[0][1];
			out_q.grain_right  <= mute_q ? '0 : snd_q[1][1];
			out_q.reverb_left  <= mute_q ? '0 : snd_q[0][2];
			out_q.reverb_right <= mute_q ? '0 : snd_q[1][2];
			out_q.input_peak   <= in_peak_q;
			out_q.output_peak  <= out_peak_new;
			out_q.block_done   <= blk_q;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	// A muted item leaves silent audio and a zero output meter.
	a_mute_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && mute_q) |=> (result.data.output_peak == '0
			&& result.data.out_left == '0 && result.data.out_right == '0))
		else $error("muted item produced nonzero output");

	// Both lanes run in lock step.
	a_lane_lock: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done[0] == mul_done[1])
		else $error("lane multipliers out of step");

	// A multiplier finishes only while the sequencer waits for it.
	a_done_place: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done[0] |-> (state_q == S_MUL_G || state_q == S_MUL_VG
			|| state_q == S_MUL_IN || state_q == S_MUL_SEND))
		else $error("multiplier done outside a multiply state");

	// The meters restart after the last item of a block.
	a_block_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && blk_q) |=> (in_peak_q == '0 && out_peak_q == '0))
		else $error("peak meters not cleared at block end");

endmodule
